>>> rtl/bfa_pkg.sv
package bfa_pkg;

   localparam int MODE_W  = 2;
   localparam int BASE_W  = 32;
   localparam int LEN_W   = 33;
   localparam int ADDR_W  = 32;
   localparam int TOTAL_W = 17;
   localparam int WORD_W  = 64;

   localparam logic [BASE_W-1:0] LOW_LIMIT = 32'h0010_0000;
   localparam logic [WORD_W-1:0] ALL_ONES  = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_FILL    = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_ALLOC   = 2'd2,
      MODE_FREE    = 2'd3
   } mode_type;

   // population count in byte groups
   function automatic logic [6:0] count_ones(input logic [WORD_W-1:0] w);
      logic [3:0] grp [8];
      logic [6:0] sum;
      sum = '0;
      for (int g = 0; g < 8; g++) begin
         grp[g] = '0;
         for (int b = 0; b < 8; b++) begin
            grp[g] = grp[g] + 4'(w[g*8+b]);
         end
      end
      for (int g = 0; g < 8; g++) begin
         sum = sum + 7'(grp[g]);
      end
      return sum;
   endfunction

   // one-hot of the lowest clear bit
   function automatic logic [WORD_W-1:0] lowest_zero_bit(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] inv;
      inv = ~w;
      return inv & (~inv + 64'd1);
   endfunction

   // index of the lowest clear bit
   function automatic logic [5:0] lowest_zero_idx(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] iso;
      logic [5:0]        idx;
      iso = lowest_zero_bit(w);
      idx = '0;
      for (int k = 0; k < 6; k++) begin
         for (int b = 0; b < WORD_W; b++) begin
            if (((b >> k) & 1) != 0) begin
               idx[k] = idx[k] | iso[b];
            end
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/bfa_req_if.sv
interface bfa_req_if import bfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BASE_W-1:0] base_addr;
   logic [LEN_W-1:0]  region_len;

   modport source (output valid, output mode, output base_addr, output region_len,
                   input ready);
   modport sink   (input valid, input mode, input base_addr, input region_len,
                   output ready);
endinterface

>>> rtl/bfa_rsp_if.sv
interface bfa_rsp_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  frame_addr;
   logic               status;
   logic [TOTAL_W-1:0] free_total;

   modport source (output valid, output frame_addr, output status, output free_total,
                   input ready);
   modport sink   (input valid, input frame_addr, input status, input free_total,
                   output ready);
endinterface

>>> rtl/bitmap_frame_allocator.sv
// Page-frame allocator over a used/free bitmap held in one synchronous RAM of
// 64-bit words, one bit per frame (1 = used). Requests come in on req (mode,
// base_addr, region_len) and each gives exactly one transfer on rsp
// (frame_addr, status, free_total). req.ready is high only while no request
// is in progress, so requests are handled one at a time; a finished result
// sits in the rsp output register while the next request is accepted.
// Steps from the req transfer to rsp.valid, with W = NUM_FRAMES/64 rounded
// up, set by the single RAM port and its registered read:
//   mark all used : all W words, one word written per cycle
//   release region: bounds, then per word touched: read, then clear and write back
//   allocate      : read and test words from the hint word on, with a wrap retry from word 0
//   free frame    : read and test the frame's bit, or straight to reply when out of range
// Reset runs a pass that sets all W words to used, with req.ready low, and
// the free count and the search hint clear at once. When rsp stalls, the
// result holds in the output register and a following request, once done,
// waits in its reply state until the register is taken.
// PAGE_BYTES must be a power of two; the block itself does not check it.
module bitmap_frame_allocator import bfa_pkg::*; #(
   parameter int PAGE_BYTES = 4096,
   parameter int NUM_FRAMES = 65536
) (
   input  logic       clock,
   input  logic       reset,
   bfa_req_if.sink    req,
   bfa_rsp_if.source  rsp
);

   localparam int SH        = $clog2(PAGE_BYTES);
   localparam int FW        = $clog2(NUM_FRAMES);
   localparam int TW        = $clog2(NUM_FRAMES + 1);
   localparam int MAP_WORDS = (NUM_FRAMES + 63) / 64;
   localparam int WW        = FW - 6;
   localparam int MAP_SPAN  = MAP_WORDS * 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_REL_PREP,
      ST_REL_RD,
      ST_REL_WR,
      ST_ALC_RD,
      ST_ALC_CHK,
      ST_FR_RD,
      ST_FR_CHK,
      ST_REPLY
   } state_type;

   logic [WORD_W-1:0] used_map [MAP_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [WORD_W-1:0] mem_wdata;

   state_type          state_ff, state_in;
   logic [WW-1:0]      word_ff, word_in;
   logic [TW-1:0]      tally_ff, tally_in;
   logic [TW-1:0]      hint_ff, hint_in;
   logic               retry_ff, retry_in;
   logic               fill_reply_ff, fill_reply_in;
   logic [BASE_W-1:0]  start_ff, start_in;
   logic [BASE_W+1:0]  end_ff, end_in;
   logic               skip_ff, skip_in;
   logic [FW-1:0]      first_ff, first_in;
   logic [FW-1:0]      lastm1_ff, lastm1_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // request decode
   logic [BASE_W+1:0] req_end;
   logic              req_below;
   logic [32:0]       free_frame;
   logic              free_oob;
   logic              hint_in_map;

   // region bounds
   logic [BASE_W+1:0] rel_first;
   logic [BASE_W+1:0] rel_last;
   logic [BASE_W+1:0] rel_last_c;

   // word datapath
   logic [WORD_W-1:0] lo_mask;
   logic [WORD_W-1:0] hi_mask;
   logic [WORD_W-1:0] rel_mask;
   logic [6:0]        rel_count;
   logic              word_full;
   logic [5:0]        zero_idx;
   logic [FW-1:0]     alc_frame;
   logic              alc_past;
   logic [FW+SH-1:0]  alc_byte;
   logic [WORD_W-1:0] fr_bit;
   logic              fr_used;
   logic              last_map_word;

   assign req_end     = (BASE_W+2)'(req.base_addr) + (BASE_W+2)'(req.region_len);
   assign req_below   = req.base_addr < LOW_LIMIT;
   assign free_frame  = 33'(req.base_addr >> SH);
   assign free_oob    = free_frame >= 33'(NUM_FRAMES);
   assign hint_in_map = {1'b0, hint_ff} < (TW+1)'(MAP_SPAN);

   assign rel_first  = ((BASE_W+2)'(start_ff) + (BASE_W+2)'(PAGE_BYTES - 1)) >> SH;
   assign rel_last   = end_ff >> SH;
   assign rel_last_c = (rel_last > (BASE_W+2)'(NUM_FRAMES)) ? (BASE_W+2)'(NUM_FRAMES)
                                                             : rel_last;

   assign lo_mask   = (word_ff == first_ff[FW-1:6]) ? (ALL_ONES << first_ff[5:0]) : ALL_ONES;
   assign hi_mask   = (word_ff == lastm1_ff[FW-1:6]) ? (ALL_ONES >> (6'd63 - lastm1_ff[5:0]))
                                                     : ALL_ONES;
   assign rel_mask  = lo_mask & hi_mask;
   assign rel_count = count_ones(rd_data_ff & rel_mask);

   assign word_full     = rd_data_ff == ALL_ONES;
   assign zero_idx      = lowest_zero_idx(rd_data_ff);
   assign alc_frame     = {word_ff, zero_idx};
   assign alc_past      = {1'b0, alc_frame} >= (FW+1)'(NUM_FRAMES);
   assign alc_byte      = {alc_frame, {SH{1'b0}}};
   assign last_map_word = word_ff == WW'(MAP_WORDS - 1);

   assign fr_bit  = 64'd1 << first_ff[5:0];
   assign fr_used = |(rd_data_ff & fr_bit);

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      tally_in      = tally_ff;
      hint_in       = hint_ff;
      retry_in      = retry_ff;
      fill_reply_in = fill_reply_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      skip_in       = skip_ff;
      first_in      = first_ff;
      lastm1_in     = lastm1_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      mem_we        = 1'b0;
      mem_wdata     = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               res_addr_in   = '0;
               res_status_in = 1'b0;
               unique case (mode_type'(req.mode))
                  MODE_FILL: begin
                     tally_in      = '0;
                     hint_in       = '0;
                     word_in       = '0;
                     fill_reply_in = 1'b1;
                     state_in      = ST_FILL;
                  end
                  MODE_RELEASE: begin
                     start_in = req_below ? LOW_LIMIT : req.base_addr;
                     end_in   = req_end;
                     skip_in  = req_below && (req_end <= (BASE_W+2)'(LOW_LIMIT));
                     state_in = ST_REL_PREP;
                  end
                  MODE_ALLOC: begin
                     if (hint_in_map) begin
                        word_in  = hint_ff[WW+5:6];
                        retry_in = |hint_ff[TW-1:6];
                     end else begin
                        hint_in  = '0;
                        word_in  = '0;
                        retry_in = 1'b0;
                     end
                     state_in = ST_ALC_RD;
                  end
                  MODE_FREE: begin
                     first_in = free_frame[FW-1:0];
                     word_in  = free_frame[FW-1:6];
                     if (free_oob) begin
                        res_status_in = 1'b1;
                        state_in      = ST_REPLY;
                     end else begin
                        state_in = ST_FR_RD;
                     end
                  end
               endcase
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = ALL_ONES;
            if (last_map_word) begin
               state_in = fill_reply_ff ? ST_REPLY : ST_IDLE;
            end else begin
               word_in = word_ff + WW'(1);
            end
         end
         ST_REL_PREP: begin
            if (skip_ff || rel_first >= rel_last_c) begin
               state_in = ST_REPLY;
            end else begin
               first_in  = rel_first[FW-1:0];
               lastm1_in = FW'(rel_last_c - (BASE_W+2)'(1));
               word_in   = rel_first[FW-1:6];
               state_in  = ST_REL_RD;
            end
         end
         ST_REL_RD: begin
            state_in = ST_REL_WR;
         end
         ST_REL_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff & ~rel_mask;
            tally_in  = tally_ff + TW'(rel_count);
            if (word_ff == lastm1_ff[FW-1:6]) begin
               state_in = ST_REPLY;
            end else begin
               word_in  = word_ff + WW'(1);
               state_in = ST_REL_RD;
            end
         end
         ST_ALC_RD: begin
            state_in = ST_ALC_CHK;
         end
         ST_ALC_CHK: begin
            if (!word_full) begin
               if (alc_past) begin
                  res_status_in = 1'b1;
               end else begin
                  mem_we      = 1'b1;
                  mem_wdata   = rd_data_ff | lowest_zero_bit(rd_data_ff);
                  tally_in    = tally_ff - TW'(1);
                  hint_in     = TW'(alc_frame) + TW'(1);
                  res_addr_in = ADDR_W'(alc_byte);
               end
               state_in = ST_REPLY;
            end else if (last_map_word) begin
               if (retry_ff) begin
                  hint_in  = '0;
                  word_in  = '0;
                  retry_in = 1'b0;
                  state_in = ST_ALC_RD;
               end else begin
                  res_status_in = 1'b1;
                  state_in      = ST_REPLY;
               end
            end else begin
               word_in  = word_ff + WW'(1);
               state_in = ST_ALC_RD;
            end
         end
         ST_FR_RD: begin
            state_in = ST_FR_CHK;
         end
         ST_FR_CHK: begin
            if (fr_used) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & ~fr_bit;
               tally_in  = tally_ff + TW'(1);
               if (TW'(first_ff) < hint_ff) begin
                  hint_in = TW'(first_ff);
               end
            end else begin
               res_status_in = 1'b1;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_total_in  = TOTAL_W'(tally_ff);
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         used_map[word_ff] <= mem_wdata;
      end
      rd_data_ff <= used_map[word_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         word_ff       <= '0;
         tally_ff      <= '0;
         hint_ff       <= '0;
         retry_ff      <= 1'b0;
         fill_reply_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_ff       <= word_in;
         tally_ff      <= tally_in;
         hint_ff       <= hint_in;
         retry_ff      <= retry_in;
         fill_reply_ff <= fill_reply_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      start_ff      <= start_in;
      end_ff        <= end_in;
      skip_ff       <= skip_in;
      first_ff      <= first_in;
      lastm1_ff     <= lastm1_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req.ready      = state_ff == ST_IDLE;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.frame_addr = rsp_addr_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.free_total = rsp_total_ff;

endmodule
